>>> rtl/core/gmsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gmsa_pkg;
  localparam int MAX_ROWS    = 16;
  localparam int MAX_COLUMNS = 64;
  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int COL_W   = $clog2(MAX_COLUMNS);
  localparam int ADDR_W  = ROW_W + COL_W;
  localparam int DEPTH   = MAX_ROWS * MAX_COLUMNS;
  localparam int SCORE_W = 32;
  localparam int LABEL_W = 5;
  localparam int RCNT_W  = ROW_W + 1;
  localparam int CCNT_W  = COL_W + 1;

  localparam logic [0:0] REG_ROW_COUNT    = 1'b0;
  localparam logic [0:0] REG_COLUMN_COUNT = 1'b1;

  typedef enum logic [2:0] {
    ST_LOAD, ST_CLEAR, ST_SCAN, ST_DRAIN, ST_COMMIT, ST_EMIT
  } state_t;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [SCORE_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
  } mem_req_t;
endpackage
`default_nettype wire

>>> rtl/core/gmsa_score_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module gmsa_score_ram import gmsa_pkg::*; (
  input  wire logic                clk,
  input  wire mem_req_t            req,
  output logic [SCORE_W-1:0]       rd_data
);
  logic [SCORE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) mem[req.wr_addr] <= req.wr_data;
    if (req.rd_en) rd_data <= mem[req.rd_addr];
  end
endmodule
`default_nettype wire

>>> rtl/core/gmsa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module gmsa_ctrl import gmsa_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [4:0]           row_count,
  input  wire logic [6:0]           column_count,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [SCORE_W-1:0]   in_score,
  input  wire logic                 in_last_score,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [5:0]                out_column_index,
  output logic [4:0]                out_assigned_label,
  output logic                      out_last_label,
  output mem_req_t                  mem_req,
  input  wire logic [SCORE_W-1:0]   mem_rd_data
);
  state_t state_r, state_nxt;
  logic [RCNT_W-1:0] rows;
  logic [CCNT_W-1:0] cols;
  logic [ADDR_W:0]   size, load_pos_r, load_pos_nxt;
  logic [MAX_ROWS-1:0]    row_taken_r, row_taken_nxt;
  logic [MAX_COLUMNS-1:0] col_taken_r, col_taken_nxt;
  logic [LABEL_W-1:0] label_r [MAX_COLUMNS];
  logic [LABEL_W-1:0] lab_q_r;
  logic              lab_ok_r, lab_ok_nxt;
  logic [RCNT_W-1:0] r_r, r_nxt;
  logic [CCNT_W-1:0] c_r, c_nxt;
  logic [ADDR_W:0]   addr_r, addr_nxt;
  logic [RCNT_W-1:0] rounds_r, rounds_nxt;
  logic              pend_r, pend_nxt;
  logic [ROW_W-1:0]  pr_r, pr_nxt;
  logic [COL_W-1:0]  pc_r, pc_nxt;
  logic              found_r, found_nxt;
  logic [SCORE_W-1:0] best_r, best_nxt;
  logic [ROW_W-1:0]  br_r, br_nxt;
  logic [COL_W-1:0]  bc_r, bc_nxt;
  logic              lab_we;
  logic [SCORE_W-1:0] ord;
  logic              skip;
  logic              out_valid_r, out_valid_nxt;
  logic [COL_W-1:0]  oc_r, oc_nxt;
  logic [LABEL_W-1:0] ol_r, ol_nxt;
  logic              olast_r, olast_nxt;

  always_comb begin
    rows = (row_count == '0) ? RCNT_W'(1) :
           (row_count > 5'(MAX_ROWS)) ? RCNT_W'(MAX_ROWS) : row_count[RCNT_W-1:0];
    cols = (column_count == '0) ? CCNT_W'(1) :
           (column_count > 7'(MAX_COLUMNS)) ? CCNT_W'(MAX_COLUMNS)
                                             : column_count[CCNT_W-1:0];
    size = (ADDR_W+1)'(rows) * (ADDR_W+1)'(cols);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD; load_pos_r <= '0; row_taken_r <= '0; col_taken_r <= '0;
      pend_r <= 1'b0; out_valid_r <= 1'b0; lab_ok_r <= 1'b0;
    end else begin
      state_r <= state_nxt; load_pos_r <= load_pos_nxt;
      row_taken_r <= row_taken_nxt; col_taken_r <= col_taken_nxt;
      pend_r <= pend_nxt; out_valid_r <= out_valid_nxt; lab_ok_r <= lab_ok_nxt;
    end
    r_r <= r_nxt; c_r <= c_nxt; addr_r <= addr_nxt; rounds_r <= rounds_nxt;
    pr_r <= pr_nxt; pc_r <= pc_nxt; found_r <= found_nxt; best_r <= best_nxt;
    br_r <= br_nxt; bc_r <= bc_nxt; oc_r <= oc_nxt; ol_r <= ol_nxt;
    olast_r <= olast_nxt;
  end

  // label store with a registered read at the emit column;
  // clearing is unnecessary: column_taken gates reads
  always_ff @(posedge clk) begin
    if (lab_we) label_r[bc_r] <= LABEL_W'({1'b0, br_r} + 1);
    lab_q_r <= label_r[c_r[COL_W-1:0]];
  end

  assign ord  = mem_rd_data ^ {1'b1, {(SCORE_W-1){1'b0}}};
  assign skip = row_taken_r[r_r[ROW_W-1:0]];

  always_comb begin
    state_nxt = state_r; load_pos_nxt = load_pos_r;
    row_taken_nxt = row_taken_r; col_taken_nxt = col_taken_r;
    r_nxt = r_r; c_nxt = c_r; addr_nxt = addr_r; rounds_nxt = rounds_r;
    pend_nxt = 1'b0; pr_nxt = pr_r; pc_nxt = pc_r;
    found_nxt = found_r; best_nxt = best_r; br_nxt = br_r; bc_nxt = bc_r;
    lab_we = 1'b0; out_valid_nxt = out_valid_r; lab_ok_nxt = 1'b0;
    oc_nxt = oc_r; ol_nxt = ol_r; olast_nxt = olast_r;
    in_ready = 1'b0;
    mem_req = '0;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;

    // candidate from previous read
    if (pend_r && (!found_r || ord > best_r)) begin
      found_nxt = 1'b1; best_nxt = ord; br_nxt = pr_r; bc_nxt = pc_r;
    end

    case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (load_pos_r < size) begin
            mem_req.wr_en = 1'b1; mem_req.wr_addr = load_pos_r[ADDR_W-1:0];
            mem_req.wr_data = in_score;
            load_pos_nxt = load_pos_r + 1'b1;
          end
          if (in_last_score) begin
            load_pos_nxt = '0; row_taken_nxt = '0; col_taken_nxt = '0;
            rounds_nxt = (RCNT_W'(cols) < rows && cols < CCNT_W'(MAX_ROWS))
                         ? RCNT_W'(cols) : rows;
            state_nxt = ST_CLEAR;
          end
        end
      end
      ST_CLEAR: begin
        r_nxt = '0; c_nxt = '0; addr_nxt = '0; found_nxt = 1'b0;
        state_nxt = (rounds_r == '0) ? ST_EMIT : ST_SCAN;
        c_nxt = '0;
      end
      ST_SCAN: begin
        // walk columns outer, rows inner; address r*cols+c
        if (!col_taken_r[c_r[COL_W-1:0]] && !skip) begin
          mem_req.rd_en = 1'b1; mem_req.rd_addr = addr_r[ADDR_W-1:0];
          pend_nxt = 1'b1; pr_nxt = r_r[ROW_W-1:0]; pc_nxt = c_r[COL_W-1:0];
        end
        if (r_r + 1'b1 == rows) begin
          r_nxt = '0;
          addr_nxt = (ADDR_W+1)'(c_r + 1'b1);
          if (c_r + 1'b1 == cols) state_nxt = ST_DRAIN;
          c_nxt = c_r + 1'b1;
        end else begin
          r_nxt = r_r + 1'b1;
          addr_nxt = addr_r + (ADDR_W+1)'(cols);
        end
      end
      ST_DRAIN: state_nxt = ST_COMMIT;
      ST_COMMIT: begin
        lab_we = 1'b1;
        row_taken_nxt[br_r] = 1'b1; col_taken_nxt[bc_r] = 1'b1;
        rounds_nxt = rounds_r - 1'b1;
        r_nxt = '0; c_nxt = '0; addr_nxt = '0; found_nxt = 1'b0;
        state_nxt = (rounds_r == RCNT_W'(1)) ? ST_EMIT : ST_SCAN;
      end
      ST_EMIT: begin
        // lab_q_r holds the label of c_r once lab_ok_r shows that c_r has held still over the registered read
        if (lab_ok_r && (!out_valid_r || out_ready)) begin
          out_valid_nxt = 1'b1;
          oc_nxt = c_r[COL_W-1:0];
          ol_nxt = col_taken_r[c_r[COL_W-1:0]] ? lab_q_r : '0;
          olast_nxt = (c_r + 1'b1 == cols);
          c_nxt = c_r + 1'b1;
          if (c_r + 1'b1 == cols) state_nxt = ST_LOAD;
        end else begin
          lab_ok_nxt = 1'b1;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  assign out_valid          = out_valid_r;
  assign out_column_index   = 6'(oc_r);
  assign out_assigned_label = ol_r;
  assign out_last_label     = olast_r;
endmodule
`default_nettype wire

>>> rtl/core/greedy_max_score_assignment.sv
`timescale 1ns / 1ps
`default_nettype none
// channel | direction | ports
// in      | input     | in_valid/in_ready, in_score, in_last_score
// out     | output    | out_valid/out_ready, out_column_index, out_assigned_label,
//         |           | out_last_label
// cfg     | input     | cfg_valid/cfg_ready, cfg_index, cfg_data
// Loading takes one score transaction per cycle into the score RAM while in the load state.
// Assignment: a setup state, then min(rows,cols) rounds, each a scan over the rows*cols
// addresses with RAM reads through the single read port, a drain and a commit; then one
// label transaction per column, each after a registered label-store read for that column.
// Reset (rst_n low, synchronous) sets counts to 16x64 and clears the taken masks.
// Results stall on out_ready through the output register.
module greedy_max_score_assignment import gmsa_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [6:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic signed [31:0] in_score,
  input  wire logic        in_last_score,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [5:0]       out_column_index,
  output logic [4:0]       out_assigned_label,
  output logic             out_last_label
);
  logic [4:0] row_count_r;
  logic [6:0] column_count_r;
  mem_req_t   req;
  logic [SCORE_W-1:0] rd_data;

  assign cfg_ready = 1'b1;

  // hold configuration registers; write on cfg transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= 5'd16; column_count_r <= 7'd64;
    end else if (cfg_valid) begin
      if (cfg_index == REG_ROW_COUNT) row_count_r <= cfg_data[4:0];
      else column_count_r <= cfg_data;
    end
  end

  gmsa_score_ram u_ram (.clk(clk), .req(req), .rd_data(rd_data));

  gmsa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .row_count(row_count_r), .column_count(column_count_r),
    .in_valid(in_valid), .in_ready(in_ready), .in_score(in_score),
    .in_last_score(in_last_score), .out_valid(out_valid), .out_ready(out_ready),
    .out_column_index(out_column_index), .out_assigned_label(out_assigned_label),
    .out_last_label(out_last_label), .mem_req(req), .mem_rd_data(rd_data)
  );

`ifndef NO_ASSERTIONS
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_column_index) &&
      $stable(out_assigned_label) && $stable(out_last_label))
    else $error("result changed while stalled");
  a_last_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_label |-> out_column_index == 6'(7'((column_count_r == 0) ? 1 :
      (column_count_r > 64) ? 64 : column_count_r) - 7'd1))
    else $error("last label on wrong column");
`endif
endmodule
`default_nettype wire
